[rtl/core/pulse_shape_response_defines.svh]
// Assertion macros shared by the pulse shape response RTL
`ifndef PULSE_SHAPE_RESPONSE_DEFINES_SVH
`define PULSE_SHAPE_RESPONSE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PSR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pulse_shape_response: assertion failed");

// next-cycle implication
`define PSR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pulse_shape_response: assertion failed");

`endif

[rtl/core/psr_pkg.sv]
// Types, constants and helpers shared by the pulse shape response RTL
package psr_pkg;

  typedef enum logic [1:0] {
    CFG_PEAK_TIME = 2'd0,
    CFG_RISE_EXP  = 2'd1,
    CFG_FALL_EXP  = 2'd2
  } cfg_idx_e;

  localparam int unsigned LOG_STEPS = 16;
  localparam int unsigned EXP_STEPS = 16;

  typedef logic [30:0]        mant_t;
  typedef logic signed [26:0] ypow_t;
  typedef logic signed [27:0] wlog_t;

  localparam mant_t Q30_ONE = 31'h4000_0000;

  // 2^(2^-k) for k = 1..16, Q30
  localparam mant_t EXP2_FACTOR [EXP_STEPS] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
    31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
    31'd1075196444, 31'd1074468888, 31'd1074105294, 31'd1073923544,
    31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
  };

  localparam mant_t        LOG2E_Q30       = 31'd1549082005;
  localparam logic [16:0]  LOG2_SCALE_Q16  = 17'd94548;
  localparam mant_t        POWER_LIMIT_Q24 = 31'd671088640;
  localparam ypow_t        Y_LIMIT         = 27'sd393216;

  // one log2 fraction lane pair: sample and peak
  typedef struct packed {
    mant_t       x_raw;
    mant_t       x_pk;
    logic [15:0] fr_raw;
    logic [15:0] fr_pk;
  } log_lane_t;

  typedef struct packed {
    logic [4:0]  top_raw;
    logic [4:0]  top_pk;
    logic [15:0] expo;
    logic        raw_zero;
    logic        kill;
  } log_side_t;

  typedef struct packed {
    ypow_t y;
    logic  kill;
  } exp1_side_t;

  typedef struct packed {
    wlog_t w;
    logic  kill;
  } exp2_side_t;

  function automatic logic [4:0] msb_index(input logic [22:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < 23; i++) begin
      if (v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

[rtl/core/psr_channels.sv]
// Stream interfaces for sample input and shape result transactions
interface psr_sample_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_time_ns;

  modport source (output valid, output sample_time_ns, input ready);
  modport sink   (input valid, input sample_time_ns, output ready);
endinterface

interface psr_shape_if;
  logic        valid;
  logic        ready;
  logic [14:0] shape_value;

  modport source (output valid, output shape_value, input ready);
  modport sink   (input valid, input shape_value, output ready);
endinterface

[rtl/core/psr_log_cell.sv]
// One log2 fraction bit for both lanes: square the mantissa and renormalize
module psr_log_cell #(
  parameter type side_t = logic
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  psr_pkg::log_lane_t lane_i,
  input  side_t             side_i,
  output logic              valid_o,
  output psr_pkg::log_lane_t lane_o,
  output side_t             side_o
);
  import psr_pkg::*;

  logic      valid_q;
  log_lane_t lane_q, lane_d;
  side_t     side_q;

  function automatic logic [31:0] sq_step(input mant_t x);
    logic [61:0] sq;
    logic [31:0] hi;
    sq = {31'b0, x} * {31'b0, x};
    hi = sq[61:30];
    // {fraction bit, new mantissa}
    return hi[31] ? {1'b1, hi[31:1]} : {1'b0, hi[30:0]};
  endfunction

  logic [31:0] st_raw, st_pk;

  always_comb begin
    st_raw        = sq_step(lane_i.x_raw);
    st_pk         = sq_step(lane_i.x_pk);
    lane_d.x_raw  = st_raw[30:0];
    lane_d.x_pk   = st_pk[30:0];
    lane_d.fr_raw = {lane_i.fr_raw[14:0], st_raw[31]};
    lane_d.fr_pk  = {lane_i.fr_pk[14:0], st_pk[31]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;
  assign side_o  = side_q;

endmodule

[rtl/core/psr_exp_cell.sv]
// One exp2 fraction bit: multiply the mantissa by its factor when the bit is set
module psr_exp_cell #(
  parameter int unsigned BitIdx = 0,
  parameter type side_t = logic
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  psr_pkg::mant_t m_i,
  input  logic [15:0]   f_i,
  input  side_t         side_i,
  output logic          valid_o,
  output psr_pkg::mant_t m_o,
  output logic [15:0]   f_o,
  output side_t         side_o
);
  import psr_pkg::*;

  localparam int unsigned FBit = 15 - BitIdx;

  logic        valid_q;
  mant_t       m_q, m_d;
  logic [15:0] f_q;
  side_t       side_q;
  logic [61:0] prod;

  always_comb begin
    prod = {31'b0, m_i} * {31'b0, EXP2_FACTOR[BitIdx]};
    m_d  = f_i[FBit] ? prod[60:30] : m_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= m_d;
      f_q    <= f_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign m_o     = m_q;
  assign f_o     = f_q;
  assign side_o  = side_q;

endmodule

[rtl/core/pulse_shape_response.sv]
// Top level: asymmetric shaper response pipeline built from log2 and exp2 cell rows
//
//  channel   dir  handshake              payload
//  sample_i  in   valid/ready            sample_time_ns  s24
//  shape_o   out  valid/ready            shape_value     u15
//  cfg       in   cfg_we_i, no stall     cfg_idx_i, cfg_data_i
//
// One transaction per cycle unless the output buffer is full; the path is built from the
// three rows of 16 cells (log2 squaring, two exp2 products) plus six stage registers.
// A 2-entry output buffer holds results; the whole pipeline stalls only when it is full.
// rst_ni clears valid bits and the buffer count and sets the config registers (1000, 6144, 6963).
`include "pulse_shape_response_defines.svh"

module pulse_shape_response #(
  parameter int unsigned RESULT_FRACTION_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  psr_sample_if.sink  sample_i,
  psr_shape_if.source shape_o
);
  import psr_pkg::*;

  localparam logic signed [12:0] FbOff = 13'(int'(RESULT_FRACTION_BITS) - 30);
  localparam logic [39:0] RMax = 40'((64'd1 << RESULT_FRACTION_BITS) - 64'd1);

  // configuration
  logic [15:0] peak_q, rise_q, fall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= 16'd1000;
      rise_q <= 16'd6144;
      fall_q <= 16'd6963;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PEAK_TIME: peak_q <= cfg_data_i;
        CFG_RISE_EXP:  rise_q <= cfg_data_i;
        CFG_FALL_EXP:  fall_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic       en;
  logic [1:0] cnt_q;

  assign en             = (cnt_q != 2'd2);
  assign sample_i.ready = en;

  // front stage
  logic [22:0] raw;
  logic        neg;
  logic [15:0] peak_eff, expo;
  log_lane_t   front_lane;
  log_side_t   front_side;

  always_comb begin
    raw      = sample_i.sample_time_ns[22:0];
    neg      = sample_i.sample_time_ns[23];
    peak_eff = (peak_q == 16'd0) ? 16'd1 : peak_q;
    expo     = (raw < {7'b0, peak_eff}) ? rise_q : fall_q;
    front_side.top_raw  = msb_index(raw);
    front_side.top_pk   = msb_index({7'b0, peak_eff});
    front_side.expo     = expo;
    front_side.raw_zero = (raw == 23'd0);
    front_side.kill     = neg || ((raw == 23'd0) && (expo != 16'd0));
    front_lane.x_raw    = 31'({8'b0, raw} << (5'd30 - front_side.top_raw));
    front_lane.x_pk     = 31'({15'b0, peak_eff} << (5'd30 - front_side.top_pk));
    front_lane.fr_raw   = '0;
    front_lane.fr_pk    = '0;
  end

  logic      lg_valid [LOG_STEPS+1];
  log_lane_t lg_lane  [LOG_STEPS+1];
  log_side_t lg_side  [LOG_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_valid[0] <= 1'b0;
    end else if (en) begin
      lg_valid[0] <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lg_lane[0] <= front_lane;
      lg_side[0] <= front_side;
    end
  end

  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
    psr_log_cell #(.side_t(log_side_t)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (lg_valid[g]),
      .lane_i  (lg_lane[g]),
      .side_i  (lg_side[g]),
      .valid_o (lg_valid[g+1]),
      .lane_o  (lg_lane[g+1]),
      .side_o  (lg_side[g+1])
    );
  end

  // y = floor(la * expo / 4096)
  logic signed [21:0] la;
  logic signed [38:0] la_x, ex_x, prod_y;
  ypow_t              y_calc;
  logic               mul_valid_q, mul_kill_q;
  ypow_t              mul_y_q;

  always_comb begin
    la     = $signed({1'b0, lg_side[LOG_STEPS].top_raw, lg_lane[LOG_STEPS].fr_raw})
           - $signed({1'b0, lg_side[LOG_STEPS].top_pk, lg_lane[LOG_STEPS].fr_pk});
    la_x   = 39'(la);
    ex_x   = 39'($signed({1'b0, lg_side[LOG_STEPS].expo}));
    prod_y = la_x * ex_x;
    y_calc = lg_side[LOG_STEPS].raw_zero ? '0 : prod_y[38:12];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (en) begin
      mul_valid_q <= lg_valid[LOG_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_y_q    <= y_calc;
      mul_kill_q <= lg_side[LOG_STEPS].kill || (y_calc >= Y_LIMIT);
    end
  end

  // p = 2^y in Q.24
  logic        e1_valid [EXP_STEPS+1];
  mant_t       e1_m     [EXP_STEPS+1];
  logic [15:0] e1_f     [EXP_STEPS+1];
  exp1_side_t  e1_side  [EXP_STEPS+1];

  assign e1_valid[0]     = mul_valid_q;
  assign e1_m[0]         = Q30_ONE;
  assign e1_f[0]         = mul_y_q[15:0];
  assign e1_side[0].y    = mul_y_q;
  assign e1_side[0].kill = mul_kill_q;

  for (genvar g = 0; g < EXP_STEPS; g++) begin : g_exp1
    psr_exp_cell #(.BitIdx(g), .side_t(exp1_side_t)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (e1_valid[g]),
      .m_i     (e1_m[g]),
      .f_i     (e1_f[g]),
      .side_i  (e1_side[g]),
      .valid_o (e1_valid[g+1]),
      .m_o     (e1_m[g+1]),
      .f_o     (e1_f[g+1]),
      .side_o  (e1_side[g+1])
    );
  end

  logic signed [10:0] ip1;
  logic signed [11:0] sh1;
  mant_t              p_calc;
  logic               sh_valid_q, sh_kill_q;
  mant_t              sh_p_q;
  ypow_t              sh_y_q;

  always_comb begin
    ip1    = e1_side[EXP_STEPS].y[26:16];
    sh1    = 12'sd6 - 12'(ip1);
    p_calc = (sh1 > 12'sd62) ? '0 : (e1_m[EXP_STEPS] >> sh1[5:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_valid_q <= 1'b0;
    end else if (en) begin
      sh_valid_q <= e1_valid[EXP_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sh_p_q    <= p_calc;
      sh_y_q    <= e1_side[EXP_STEPS].y;
      sh_kill_q <= e1_side[EXP_STEPS].kill || (p_calc >= POWER_LIMIT_Q24);
    end
  end

  // z = p * log2(e)
  logic [61:0] prod_z;
  logic        z_valid_q, z_kill_q;
  logic [23:0] z_q;
  ypow_t       z_y_q;

  assign prod_z = {31'b0, sh_p_q} * {31'b0, LOG2E_Q30};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_valid_q <= 1'b0;
    end else if (en) begin
      z_valid_q <= sh_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      z_q      <= prod_z[61:38];
      z_y_q    <= sh_y_q;
      z_kill_q <= sh_kill_q;
    end
  end

  // w = y - z + log2(2.71828)
  wlog_t w_calc;
  logic  w_valid_q, w_kill_q;
  wlog_t w_q;

  assign w_calc = 28'(z_y_q) - $signed({4'b0, z_q}) + $signed({11'b0, LOG2_SCALE_Q16});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
    end else if (en) begin
      w_valid_q <= z_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q      <= w_calc;
      w_kill_q <= z_kill_q;
    end
  end

  logic        e2_valid [EXP_STEPS+1];
  mant_t       e2_m     [EXP_STEPS+1];
  logic [15:0] e2_f     [EXP_STEPS+1];
  exp2_side_t  e2_side  [EXP_STEPS+1];

  assign e2_valid[0]     = w_valid_q;
  assign e2_m[0]         = Q30_ONE;
  assign e2_f[0]         = w_q[15:0];
  assign e2_side[0].w    = w_q;
  assign e2_side[0].kill = w_kill_q;

  for (genvar g = 0; g < EXP_STEPS; g++) begin : g_exp2
    psr_exp_cell #(.BitIdx(g), .side_t(exp2_side_t)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (e2_valid[g]),
      .m_i     (e2_m[g]),
      .f_i     (e2_f[g]),
      .side_i  (e2_side[g]),
      .valid_o (e2_valid[g+1]),
      .m_o     (e2_m[g+1]),
      .f_o     (e2_f[g+1]),
      .side_o  (e2_side[g+1])
    );
  end

  // final scale, saturate
  logic signed [12:0] s2, nsh2;
  logic [39:0]        r, r_sat;
  logic [14:0]        shape_calc;
  logic               fin_valid_q, fin_kill_q;
  logic [14:0]        fin_shape_q;

  always_comb begin
    s2   = 13'($signed(e2_side[EXP_STEPS].w[27:16])) + FbOff;
    nsh2 = -s2;
    if (s2 >= 13'sd0) begin
      r = {9'b0, e2_m[EXP_STEPS]} << s2[3:0];
    end else if (nsh2 > 13'sd62) begin
      r = '0;
    end else begin
      r = {9'b0, e2_m[EXP_STEPS]} >> nsh2[5:0];
    end
    r_sat      = (r > RMax) ? RMax : r;
    shape_calc = e2_side[EXP_STEPS].kill ? 15'd0 : r_sat[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (en) begin
      fin_valid_q <= e2_valid[EXP_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_shape_q <= shape_calc;
      fin_kill_q  <= e2_side[EXP_STEPS].kill;
    end
  end

  // output buffer, two entries
  logic [14:0] buf0_q, buf1_q;
  logic        push, pop;

  assign push = fin_valid_q && en;
  assign pop  = shape_o.valid && shape_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case ({push, pop})
      2'b10: begin
        if (cnt_q == 2'd0) begin
          buf0_q <= fin_shape_q;
        end else begin
          buf1_q <= fin_shape_q;
        end
      end
      2'b01: begin
        buf0_q <= buf1_q;
      end
      2'b11: begin
        buf0_q <= fin_shape_q;
      end
      default: ;
    endcase
  end

  assign shape_o.valid       = (cnt_q != 2'd0);
  assign shape_o.shape_value = buf0_q;

  `PSR_ASSERT_NXT(a_stall_holds_final, !en, $stable(fin_valid_q) && $stable(fin_shape_q))
  `PSR_ASSERT_NXT(a_neg_sample_killed, sample_i.valid && en && neg, lg_side[0].kill)
  `PSR_ASSERT_NXT(a_killed_gives_zero, push && fin_kill_q && cnt_q == 2'd0, shape_o.valid && shape_o.shape_value == 15'd0)

endmodule

[dv/tb_top.sv]
// Testbench for pulse_shape_response: directed table, random phases, self-checking predictor
module tb_top;
  import psr_pkg::*;

  typedef struct {
    logic signed [23:0] t;
    bit                 has_exp;
    logic [14:0]        exp_val;
  } vec_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 70;
  localparam int PHASE_ITEMS    = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  psr_sample_if sample_if();
  psr_shape_if  shape_if();

  pulse_shape_response u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_if),
    .shape_o    (shape_if)
  );

  logic [15:0] peak_reg;
  logic [15:0] rise_reg;
  logic [15:0] fall_reg;

  logic [14:0] shape_q[$];
  int          n_sent;
  int          n_checked;
  int          n_errors;
  int          idle_cnt;
  bit          quiet_phase;
  bit          done;

  localparam longint unsigned EXP2_TAB [16] = '{
    1518500250, 1276901417, 1170923762, 1121280436,
    1097253708, 1085434106, 1079572136, 1076653033,
    1075196444, 1074468888, 1074105294, 1073923544,
    1073832680, 1073787251, 1073764537, 1073753181
  };

  function automatic longint log2_fix(longint unsigned n);
    int              top;
    longint unsigned x;
    longint          frac;
    top  = 0;
    frac = 0;
    while (top < 31 && (n >> (top + 1)) != 0) top++;
    x = n << (30 - top);
    for (int b = 0; b < 16; b++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(top) << 16) + frac;
  endfunction

  function automatic longint unsigned exp2_fix(longint y, int fb);
    longint          ip;
    longint          fr;
    longint unsigned m;
    longint          s;
    ip = y >>> 16;
    fr = y - ip * 65536;
    m  = 64'd1 << 30;
    for (int b = 0; b < 16; b++) begin
      if (fr[15-b]) m = (m * EXP2_TAB[b]) >> 30;
    end
    s = ip + fb - 30;
    if (s >= 0) begin
      if (s > 32) return '1;
      return m << s;
    end
    if (s <= -63) return 0;
    return m >> (-s);
  endfunction

  function automatic logic [14:0] shape_of(logic signed [23:0] t);
    longint unsigned raw;
    longint unsigned pk;
    longint unsigned ex;
    longint unsigned p;
    longint unsigned z;
    longint unsigned r;
    longint          y;
    longint          w;
    if (t < 0) return '0;
    raw = longint'(t);
    pk  = (peak_reg == 0) ? 1 : peak_reg;
    ex  = (raw < pk) ? rise_reg : fall_reg;
    if (raw == 0) begin
      if (ex != 0) return '0;
      y = 0;
    end else begin
      y = ((log2_fix(raw) - log2_fix(pk)) * longint'(ex)) >>> 12;
    end
    if (y >= (64'sd6 << 16)) return '0;
    p = exp2_fix(y, 24);
    if (p >= (64'd40 << 24)) return '0;
    z = (p * 64'd1549082005) >> 38;
    w = y - longint'(z) + 94548;
    r = exp2_fix(w, 15);
    if (r > 32767) r = 32767;
    return r[14:0];
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_PEAK_TIME: peak_reg = v;
      CFG_RISE_EXP:  rise_reg = v;
      default:       fall_reg = v;
    endcase
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid stays high between back-to-back transactions; data changes on the falling edge
  task automatic send_sample(logic signed [23:0] t);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      sample_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_if.valid          = 1'b1;
    sample_if.sample_time_ns = t;
    do @(posedge clk_i); while (!sample_if.ready);
    shape_q.push_back(shape_of(t));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    sample_if.valid = 1'b0;
    while (shape_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [23:0] rand_sample();
    int          r;
    int unsigned pk;
    r  = $urandom_range(0, 99);
    pk = (peak_reg == 0) ? 1 : peak_reg;
    if (r < 5) return '0;
    if (r < 15) return -24'($urandom_range(1, 8388608));
    if (r < 25) return 24'($urandom);
    return 24'($urandom_range(0, pk * 3));
  endfunction

  // receiver with random back-pressure and one long hold-off
  initial begin
    int hold;
    bit held;
    shape_if.ready = 1'b0;
    hold = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && n_checked >= 400) begin
        held = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        shape_if.ready = 1'b0;
      end else if (quiet_phase) begin
        shape_if.ready = 1'b1;
      end else begin
        shape_if.ready = ($urandom_range(0, 99) < 70) ||
                         ($urandom_range(0, 99) < 3 ? 1'b0 : 1'b0);
        if ($urandom_range(0, 199) == 0) hold = $urandom_range(10, 60);
      end
    end
  end

  always @(posedge clk_i) begin
    logic [14:0] want;
    if (rst_ni && shape_if.valid && shape_if.ready) begin
      if (shape_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected transaction shape_value=%0d",
                                     shape_if.shape_value);
      end else begin
        want = shape_q.pop_front();
        if (shape_if.shape_value !== want) begin
          n_errors++;
          if (n_errors <= 10) $display("mismatch shape_value exp=%0d act=%0d",
                                       want, shape_if.shape_value);
        end
      end
      n_checked++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (sample_if.valid && sample_if.ready) ||
        (shape_if.valid && shape_if.ready)) begin
      idle_cnt <= 0;
    end else if (!done) begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    vec_t        dir_tab[$];
    logic [15:0] ph_cfg[$][3];
    logic [15:0] c[3];
    logic [14:0] got;
    n_sent      = 0;
    n_checked   = 0;
    n_errors    = 0;
    idle_cnt    = 0;
    quiet_phase = 1'b0;
    done        = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_PEAK_TIME;
    cfg_data_i  = '0;
    sample_if.valid          = 1'b0;
    sample_if.sample_time_ns = '0;
    peak_reg = 16'd1000;
    rise_reg = 16'd6144;
    fall_reg = 16'd6963;
    rst_ni   = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset register values: negative, zero and huge times give zero
    dir_tab = '{
      '{-24'sd1, 1, 15'd0}, '{-24'sd8388608, 1, 15'd0}, '{24'sd0, 1, 15'd0},
      '{24'sd8388607, 1, 15'd0}, '{24'sd1, 0, 15'd0}, '{24'sd999, 0, 15'd0},
      '{24'sd1000, 0, 15'd0}, '{24'sd1001, 0, 15'd0}, '{24'sd500, 0, 15'd0},
      '{24'sd2000, 0, 15'd0}, '{24'sd6000, 0, 15'd0}, '{24'sd100, 0, 15'd0},
      '{24'sh555555, 0, 15'd0}, '{24'sh2AAAAA, 0, 15'd0}, '{24'sd1500, 0, 15'd0}
    };
    foreach (dir_tab[i]) begin
      if (dir_tab[i].has_exp) begin
        got = shape_of(dir_tab[i].t);
        if (got !== dir_tab[i].exp_val) begin
          n_errors++;
          $display("predictor disagrees on row %0d: %0d", i, got);
        end
      end
      send_sample(dir_tab[i].t);
    end
    settle();

    ph_cfg = '{
      '{16'd1000, 16'd6144, 16'd6963}, '{16'd0, 16'd6144, 16'd6963},
      '{16'd1, 16'd0, 16'd65535}, '{16'd65535, 16'd65535, 16'd0},
      '{16'd200, 16'd4096, 16'd4096}, '{16'd3000, 16'd12288, 16'd2048},
      '{16'd50, 16'd0, 16'd0}, '{16'd65535, 16'd1, 16'd65535}
    };
    for (int ph = 0; ph < 13; ph++) begin
      if (ph < ph_cfg.size()) begin
        c = ph_cfg[ph];
      end else begin
        c[0] = 16'($urandom_range(1, 65535));
        c[1] = 16'($urandom_range(0, 20000));
        c[2] = 16'($urandom_range(0, 20000));
      end
      write_reg(CFG_PEAK_TIME, c[0]);
      write_reg(CFG_RISE_EXP, c[1]);
      write_reg(CFG_FALL_EXP, c[2]);
      quiet_phase = (ph % 4 == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) send_sample(rand_sample());
      settle();
    end
    done = 1'b1;

    $display("covered %0d sample transactions over 14 register settings, %0d results checked",
             n_sent, n_checked);
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
